// ===== src/assert_macros.svh =====
// Assertion macros used by the top level to check this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/crb_pkg.sv =====
// Shared types, constants and helper functions of the cubic root bisection block.
`timescale 1ns / 1ps

package crb_pkg;

    // Field widths
    localparam int COEF_W  = 32;
    localparam int POS_W   = 32;
    localparam int CNT_W   = 6;
    localparam int ACC_W   = 128;
    localparam int VAL_W   = 96;
    localparam int ADDR_W  = 2;

    // Bound on the number of halvings
    localparam logic [CNT_W-1:0] MAX_HALVINGS = 6'd32;

    // Configuration register indexes
    localparam logic [ADDR_W-1:0] REG_LOWER_BOUND   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_UPPER_BOUND   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_HALVING_COUNT = 2'd2;

    // Reset values of the configuration registers
    localparam logic [POS_W-1:0] LOWER_RESET = 32'hE200_0000;   // -30.0 in Q7.24
    localparam logic [POS_W-1:0] UPPER_RESET = 32'h3200_0000;   // 50.0 in Q7.24
    localparam logic [CNT_W-1:0] COUNT_RESET = 6'd27;

    // Outcome of one polynomial evaluation
    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } eval_res_t;

    // Floor of the half sum of two signed Q7.24 positions
    function automatic logic [POS_W-1:0] midpoint(input logic [POS_W-1:0] lo,
                                                  input logic [POS_W-1:0] hi);
        logic signed [POS_W:0] sum;
        begin
            sum = $signed({lo[POS_W-1], lo}) + $signed({hi[POS_W-1], hi});
            midpoint = sum[POS_W:1];
        end
    endfunction

    // Clamp the halving count into one to MAX_HALVINGS
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] n);
        begin
            if (n == '0)
            begin
                clamp_count = 6'd1;
            end
            else if (n > MAX_HALVINGS)
            begin
                clamp_count = MAX_HALVINGS;
            end
            else
            begin
                clamp_count = n;
            end
        end
    endfunction

endpackage

// ===== src/cubic_root_bisection_unit.sv =====
// Top level of the cubic root bisection block: configuration registers and units.
//
// Usage: an input item carries the four Q16.16 coefficients of a cubic and is
// taken when in_valid is high and in_stall is low. The block bisects the
// interval held in the lower_bound and upper_bound registers (Q7.24) for
// halving_count steps (zero counts as one, above 32 as 32) and returns one
// item: the last midpoint and a flag that the cubic was exactly zero there.
// Each evaluation of the cubic runs in the Horner unit on the one shared
// 33x32 multiplier (1, 2 and 3 partial products for the three Horner steps,
// each step followed by an accumulate), started by a registered strobe from
// the sequencer; the evaluations of an item run one after another. An item
// needs N+1 evaluations for N halvings, fewer on an early exact zero.
// in_stall stays high for the whole search.
// Results wait in an output register; while out_stall is high the result
// holds and a new item is still accepted, but a finished search waits for
// the register to empty. Configuration writes (cfg_we, cfg_addr, cfg_data)
// take effect at the next accepted item. Reset restores the register
// defaults (-30.0, 50.0, 27) and drops any item in flight.
`timescale 1ns / 1ps

module cubic_root_bisection_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [crb_pkg::ADDR_W-1:0] cfg_addr,
    input  logic [crb_pkg::POS_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [crb_pkg::COEF_W-1:0] coef_cubic,
    input  logic [crb_pkg::COEF_W-1:0] coef_square,
    input  logic [crb_pkg::COEF_W-1:0] coef_linear,
    input  logic [crb_pkg::COEF_W-1:0] coef_const,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [crb_pkg::POS_W-1:0]  root_estimate,
    output logic                       exact_zero
);
    import crb_pkg::*;

    `include "assert_macros.svh"

    logic [POS_W-1:0]  lower_bound_reg;
    logic [POS_W-1:0]  upper_bound_reg;
    logic [CNT_W-1:0]  halving_count_reg;
    logic              eval_start;
    logic [POS_W-1:0]  eval_x;
    logic [COEF_W-1:0] eval_a, eval_b, eval_c, eval_d;
    eval_res_t         eval_res;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bound_reg   <= LOWER_RESET;
            upper_bound_reg   <= UPPER_RESET;
            halving_count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_LOWER_BOUND:   lower_bound_reg   <= cfg_data;
                REG_UPPER_BOUND:   upper_bound_reg   <= cfg_data;
                REG_HALVING_COUNT: halving_count_reg <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    crb_search u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .coef_cubic    (coef_cubic),
        .coef_square   (coef_square),
        .coef_linear   (coef_linear),
        .coef_const    (coef_const),
        .cfg_lower     (lower_bound_reg),
        .cfg_upper     (upper_bound_reg),
        .cfg_count     (halving_count_reg),
        .eval_start    (eval_start),
        .eval_x        (eval_x),
        .eval_a        (eval_a),
        .eval_b        (eval_b),
        .eval_c        (eval_c),
        .eval_d        (eval_d),
        .eval_res      (eval_res),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .root_estimate (root_estimate),
        .exact_zero    (exact_zero)
    );

    crb_horner u_horner (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eval_start),
        .x      (eval_x),
        .coef_a (eval_a),
        .coef_b (eval_b),
        .coef_c (eval_c),
        .coef_d (eval_d),
        .res    (eval_res)
    );

    // An accepted item keeps the block busy
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // A new result appears only at the end of a search
    `ASSERT_IMPL(a_result_from_search, clk, rst_n, $rose(out_valid), $past(in_stall))
    // An evaluation never starts while one is finishing
    `ASSERT_IMPL(a_no_start_on_done, clk, rst_n, eval_start, !eval_res.done)

endmodule

// ===== src/crb_horner.sv =====
// Horner evaluation of the cubic on one shared 33x32 multiplier and a 128-bit accumulator.
`timescale 1ns / 1ps

module crb_horner (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [crb_pkg::POS_W-1:0]  x,
    input  logic [crb_pkg::COEF_W-1:0] coef_a,
    input  logic [crb_pkg::COEF_W-1:0] coef_b,
    input  logic [crb_pkg::COEF_W-1:0] coef_c,
    input  logic [crb_pkg::COEF_W-1:0] coef_d,
    output crb_pkg::eval_res_t         res
);
    import crb_pkg::*;

    // Horner step 0..2 uses step+1 chunks of 32 bits of the running value
    logic [VAL_W-1:0]     v_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [1:0]           step_reg;
    logic [1:0]           k_reg;
    logic                 issue_reg;
    logic signed [64:0]   prod_reg;
    logic [1:0]           prod_k_reg;
    logic                 prod_last_reg;
    logic                 prod_valid_reg;
    logic                 done_reg;
    logic                 zero_reg;
    logic                 neg_reg;

    logic [COEF_W-1:0]    chunk;
    logic signed [32:0]   chunk_s;
    logic [ACC_W-1:0]     addend;
    logic [ACC_W-1:0]     sum;
    logic [ACC_W-1:0]     term_next;

    // Select the chunk; the top chunk of a step carries the sign
    always_comb
    begin
        chunk   = v_reg[{k_reg, 5'b0} +: COEF_W];
        chunk_s = (k_reg == step_reg) ? $signed({chunk[COEF_W-1], chunk})
                                      : $signed({1'b0, chunk});
        addend  = {{(ACC_W-65){prod_reg[64]}}, prod_reg} << {prod_k_reg, 5'b0};
        sum     = acc_reg + addend;
        term_next = (step_reg == 2'd0) ? {{48{coef_c[COEF_W-1]}}, coef_c, 48'b0}
                                       : {{24{coef_d[COEF_W-1]}}, coef_d, 72'b0};
    end

    // Multiply stage: one partial product per cycle while issue_reg is set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= 1'b0;
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg       <= 1'b0;
            prod_valid_reg <= issue_reg;
            if (start)
            begin
                issue_reg <= 1'b1;
            end
            else if (issue_reg && (k_reg == step_reg))
            begin
                issue_reg <= 1'b0;
            end
            else if (prod_valid_reg && prod_last_reg && (step_reg != 2'd2))
            begin
                issue_reg <= 1'b1;
            end
            if (prod_valid_reg && prod_last_reg && (step_reg == 2'd2))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: load terms, issue chunks, accumulate shifted products
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= {{(VAL_W-COEF_W){coef_a[COEF_W-1]}}, coef_a};
            acc_reg  <= {{72{coef_b[COEF_W-1]}}, coef_b, 24'b0};
            step_reg <= 2'd0;
            k_reg    <= 2'd0;
        end
        else
        begin
            if (issue_reg)
            begin
                prod_reg      <= chunk_s * $signed(x);
                prod_k_reg    <= k_reg;
                prod_last_reg <= (k_reg == step_reg);
                if (k_reg != step_reg)
                begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            if (prod_valid_reg)
            begin
                if (prod_last_reg && (step_reg != 2'd2))
                begin
                    // Advance to the next Horner step
                    v_reg    <= sum[VAL_W-1:0];
                    acc_reg  <= term_next;
                    step_reg <= step_reg + 2'd1;
                    k_reg    <= 2'd0;
                end
                else
                begin
                    acc_reg <= sum;
                end
            end
        end
        zero_reg <= (sum == '0);
        neg_reg  <= sum[ACC_W-1];
    end

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.neg  = neg_reg;

endmodule

// ===== src/crb_search.sv =====
// Bisection sequencer: interval bounds, halving counter and output register.
`timescale 1ns / 1ps

module crb_search (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [crb_pkg::COEF_W-1:0] coef_cubic,
    input  logic [crb_pkg::COEF_W-1:0] coef_square,
    input  logic [crb_pkg::COEF_W-1:0] coef_linear,
    input  logic [crb_pkg::COEF_W-1:0] coef_const,
    input  logic [crb_pkg::POS_W-1:0]  cfg_lower,
    input  logic [crb_pkg::POS_W-1:0]  cfg_upper,
    input  logic [crb_pkg::CNT_W-1:0]  cfg_count,
    output logic                       eval_start,
    output logic [crb_pkg::POS_W-1:0]  eval_x,
    output logic [crb_pkg::COEF_W-1:0] eval_a,
    output logic [crb_pkg::COEF_W-1:0] eval_b,
    output logic [crb_pkg::COEF_W-1:0] eval_c,
    output logic [crb_pkg::COEF_W-1:0] eval_d,
    input  crb_pkg::eval_res_t         eval_res,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [crb_pkg::POS_W-1:0]  root_estimate,
    output logic                       exact_zero
);
    import crb_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOWER  = 2'd1;
    localparam logic [1:0] ST_MID    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [COEF_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [POS_W-1:0]  lo_reg, lo_next;
    logic [POS_W-1:0]  hi_reg, hi_next;
    logic [POS_W-1:0]  x_reg, x_next;
    logic              plo_zero_reg, plo_zero_next;
    logic              plo_neg_reg, plo_neg_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg;
    logic              zflag_reg, zflag_next;
    logic              start_reg, start_next;
    logic              out_valid_reg, out_valid_next;
    logic [POS_W-1:0]  root_reg, root_next;
    logic              out_zero_reg, out_zero_next;
    logic              accept;
    logic              go_upper;
    logic [POS_W-1:0]  sel_lo, sel_hi, mid;
    logic [CNT_W-1:0]  cnt_inc;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign go_upper = !plo_zero_reg && (eval_res.neg != plo_neg_reg);
    assign cnt_inc  = cnt_reg + 6'd1;

    // Pick the half interval that the next midpoint splits
    always_comb
    begin
        if ((state_reg == ST_MID) && go_upper)
        begin
            sel_lo = lo_reg;
            sel_hi = x_reg;
        end
        else if (state_reg == ST_MID)
        begin
            sel_lo = x_reg;
            sel_hi = hi_reg;
        end
        else
        begin
            sel_lo = lo_reg;
            sel_hi = hi_reg;
        end
        mid = midpoint(sel_lo, sel_hi);
    end

    // Sequence the evaluations of one item
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        plo_zero_next  = plo_zero_reg;
        plo_neg_next   = plo_neg_reg;
        cnt_next       = cnt_reg;
        zflag_next     = zflag_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        root_next      = root_reg;
        out_zero_next  = out_zero_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    lo_next    = cfg_lower;
                    hi_next    = cfg_upper;
                    x_next     = cfg_lower;
                    start_next = 1'b1;
                    state_next = ST_LOWER;
                end
            end
            ST_LOWER:
            begin
                if (eval_res.done)
                begin
                    plo_zero_next = eval_res.zero;
                    plo_neg_next  = eval_res.neg;
                    cnt_next      = '0;
                    x_next        = mid;
                    start_next    = 1'b1;
                    state_next    = ST_MID;
                end
            end
            ST_MID:
            begin
                if (eval_res.done)
                begin
                    if (eval_res.zero)
                    begin
                        zflag_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // Keep the half whose ends differ in sign
                        lo_next  = sel_lo;
                        hi_next  = sel_hi;
                        cnt_next = cnt_inc;
                        if (!go_upper)
                        begin
                            plo_zero_next = 1'b0;
                            plo_neg_next  = eval_res.neg;
                        end
                        if (cnt_inc == n_reg)
                        begin
                            zflag_next = 1'b0;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            x_next     = mid;
                            start_next = 1'b1;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    root_next      = x_reg;
                    out_zero_next  = zflag_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg <= coef_cubic;
            b_reg <= coef_square;
            c_reg <= coef_linear;
            d_reg <= coef_const;
            n_reg <= clamp_count(cfg_count);
        end
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        x_reg        <= x_next;
        plo_zero_reg <= plo_zero_next;
        plo_neg_reg  <= plo_neg_next;
        cnt_reg      <= cnt_next;
        zflag_reg    <= zflag_next;
        root_reg     <= root_next;
        out_zero_reg <= out_zero_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign eval_start    = start_reg;
    assign eval_x        = x_reg;
    assign eval_a        = a_reg;
    assign eval_b        = b_reg;
    assign eval_c        = c_reg;
    assign eval_d        = d_reg;
    assign out_valid     = out_valid_reg;
    assign root_estimate = root_reg;
    assign exact_zero    = out_zero_reg;

endmodule
